[src/bslpc_pkg.sv]
// Shared types, constants and codes for the button press classifier.
`timescale 1ns / 1ps
`default_nettype none

package bslpc_pkg;

  // Field widths fixed by the interface
  localparam int CODE_W  = 4;
  localparam int DELTA_W = 16;
  localparam int CFG_W   = 32;
  localparam int Q_FRAC  = 12;
  localparam int PROG_W  = Q_FRAC + 1;
  localparam int CFG_IDX_W = 2;

  // Default parameter values
  localparam int DEF_TIME_BITS = 32;
  localparam int DEF_CODE_BITS = 4;

  // Register reset values
  localparam logic [CODE_W-1:0] RST_TARGET = CODE_W'(1);
  localparam logic [CFG_W-1:0]  RST_HOLD   = CFG_W'(1000);
  localparam logic [CFG_W-1:0]  RST_WINDOW = CFG_W'(300);

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET = 2'd0,
    CFG_HOLD   = 2'd1,
    CFG_WINDOW = 2'd2
  } cfg_idx_e;

  // Event codes
  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } event_e;

  typedef struct packed {
    logic [CODE_W-1:0]  next_code;
    logic [DELTA_W-1:0] delta_ticks;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        press_event;
    logic              in_long_press;
    logic [PROG_W-1:0] progress;
  } out_word_t;

  // Controller to datapath
  typedef struct packed {
    logic in_load;
    logic add;
    logic eval;
    logic div_step;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_div;
  } sts_t;

endpackage

`default_nettype wire

[src/button_short_long_press_classifier.sv]
// Top level of the button short / long press classifier.
//
//  channel | direction | handshake              | word
//  --------+-----------+------------------------+----------------------------
//  in      | input     | in_valid_i / in_ready_o   | next_code, delta_ticks
//  out     | output    | out_valid_o / out_ready_i | press_event, in_long_press,
//          |           |                        | progress
//  cfg     | input     | cfg_we_i, no wait      | cfg_idx_i, cfg_wdata_i
//
// One word at a time: accept, add, evaluate, then a result load.
// While the target is held between window and hold, the Q12 progress comes
// from a restoring divider at one bit a cycle.
// Reset is asynchronous; no clearing pass, the block takes words at once.
// A result waits in the output register; the next word is taken meanwhile,
// and its result load stalls until the previous result has been taken.
`timescale 1ns / 1ps
`default_nettype none

module button_short_long_press_classifier import bslpc_pkg::*; #(
  parameter int TIME_BITS = DEF_TIME_BITS,
  parameter int CODE_BITS = DEF_CODE_BITS
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire in_word_t             in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output out_word_t                 out_data_o
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  bslpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // State and arithmetic
  bslpc_datapath #(
    .TIME_BITS (TIME_BITS),
    .CODE_BITS (CODE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

[src/bslpc_datapath.sv]
// Datapath: registers, press state, time update, compares and progress divider.
`timescale 1ns / 1ps
`default_nettype none

module bslpc_datapath import bslpc_pkg::*; #(
  parameter int TIME_BITS = DEF_TIME_BITS,
  parameter int CODE_BITS = DEF_CODE_BITS
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  input  wire in_word_t             in_data_i,
  input  wire cmd_t                 cmd_i,
  output sts_t                      sts_o,
  output out_word_t                 out_data_o
);

  localparam int KeepBits = (CODE_BITS < CODE_W) ? CODE_BITS : CODE_W;
  localparam int CmpW     = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;
  localparam int SumW     = ((TIME_BITS > DELTA_W) ? TIME_BITS : DELTA_W) + 1;

  // Configuration
  logic [KeepBits-1:0] target_q;
  logic [CFG_W-1:0]    hold_q;
  logic [CFG_W-1:0]    win_q;

  // Press state
  logic [KeepBits-1:0]  held_code_q;
  logic [TIME_BITS-1:0] held_time_q;
  logic                 fired_q;
  logic                 pending_q;

  // Latched word and intermediates
  logic [KeepBits-1:0]  code_q;
  logic [DELTA_W-1:0]   delta_q;
  logic [TIME_BITS-1:0] t_q;
  logic [CFG_W-1:0]     span_q;
  logic                 span_ok_q;
  logic                 held_gt_win_q;
  event_e               event_q;
  logic                 pend_out_q;
  logic                 top_q;
  logic [Q_FRAC-1:0]    quo_q;
  logic [CFG_W-1:0]     rem_q;
  out_word_t            out_q;

  // Add stage
  logic [SumW-1:0]      sum;
  logic [TIME_BITS-1:0] t_sat;
  logic [CFG_W:0]       span_diff;
  logic                 span_ok;
  logic                 held_gt_win;

  // Evaluate stage
  logic [CmpW:0]      tdiff;
  logic               t_ge_win;
  logic               t_gt_win;
  logic               t_gt_hold;
  logic [CFG_W-1:0]   num;
  logic               num_eq_span;
  logic               changed;
  logic               is_target;
  logic               held_is_target;
  logic               need_div;
  logic               pend_new;

  // Divider step
  logic [CFG_W:0]     rem_sh;
  logic [CFG_W+1:0]   rem_sub;
  logic               q_bit;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= RST_TARGET[KeepBits-1:0];
      hold_q   <= RST_HOLD;
      win_q    <= RST_WINDOW;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TARGET: target_q <= cfg_wdata_i[KeepBits-1:0];
        CFG_HOLD:   hold_q   <= cfg_wdata_i;
        CFG_WINDOW: win_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Saturating time sum, window span
  always_comb begin
    sum         = SumW'(held_time_q) + SumW'(delta_q);
    t_sat       = (|sum[SumW-1:TIME_BITS]) ? '1 : sum[TIME_BITS-1:0];
    span_diff   = {1'b0, hold_q} - {1'b0, win_q};
    span_ok     = !span_diff[CFG_W] && (|span_diff[CFG_W-1:0]);
    held_gt_win = CmpW'(held_time_q) > CmpW'(win_q);
  end

  // Compares against window and hold
  always_comb begin
    tdiff          = {1'b0, CmpW'(t_q)} - {1'b0, CmpW'(win_q)};
    t_ge_win       = !tdiff[CmpW];
    t_gt_win       = t_ge_win && (|tdiff[CmpW-1:0]);
    t_gt_hold      = CmpW'(t_q) > CmpW'(hold_q);
    num            = tdiff[CFG_W-1:0];
    num_eq_span    = num == span_q;
    changed        = held_code_q != code_q;
    is_target      = code_q == target_q;
    held_is_target = held_code_q == target_q;
    need_div       = !changed && is_target && !fired_q && !t_gt_hold &&
                     span_ok_q && t_ge_win;
    pend_new       = pending_q || t_gt_win;
  end

  assign sts_o.need_div = need_div;

  // Restoring division, one quotient bit per step
  always_comb begin
    rem_sh  = {rem_q, 1'b0};
    rem_sub = {1'b0, rem_sh} - {2'b00, span_q};
    q_bit   = !rem_sub[CFG_W+1];
  end

  // Press state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_code_q <= '0;
      held_time_q <= '0;
      fired_q     <= 1'b0;
      pending_q   <= 1'b0;
    end else if (cmd_i.eval) begin
      if (changed) begin
        held_code_q <= code_q;
        held_time_q <= '0;
        fired_q     <= 1'b0;
        pending_q   <= 1'b0;
      end else if (is_target && !fired_q) begin
        if (t_gt_hold) begin
          held_time_q <= '0;
          fired_q     <= 1'b1;
          pending_q   <= 1'b0;
        end else begin
          held_time_q <= t_q;
          pending_q   <= pend_new;
        end
      end
    end
  end

  // Word latch, intermediates, divider and result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      code_q  <= in_data_i.next_code[KeepBits-1:0];
      delta_q <= in_data_i.delta_ticks;
    end
    if (cmd_i.add) begin
      t_q           <= t_sat;
      span_q        <= span_diff[CFG_W-1:0];
      span_ok_q     <= span_ok;
      held_gt_win_q <= held_gt_win;
    end
    if (cmd_i.eval) begin
      quo_q <= '0;
      rem_q <= (need_div && !num_eq_span) ? num : '0;
      if (changed) begin
        event_q    <= (held_is_target && !fired_q &&
                       !((win_q != '0) && held_gt_win_q)) ? EV_SHORT : EV_NONE;
        pend_out_q <= 1'b0;
        top_q      <= 1'b0;
      end else if (is_target && !fired_q) begin
        if (t_gt_hold) begin
          event_q    <= EV_LONG;
          pend_out_q <= 1'b0;
          top_q      <= 1'b1;
        end else begin
          event_q    <= EV_NONE;
          pend_out_q <= pend_new;
          top_q      <= need_div && num_eq_span;
        end
      end else begin
        event_q    <= EV_NONE;
        pend_out_q <= pending_q;
        top_q      <= 1'b0;
      end
    end
    if (cmd_i.div_step) begin
      rem_q <= q_bit ? rem_sub[CFG_W-1:0] : rem_sh[CFG_W-1:0];
      quo_q <= {quo_q[Q_FRAC-2:0], q_bit};
    end
    if (cmd_i.out_load) begin
      out_q.press_event   <= event_q;
      out_q.in_long_press <= pend_out_q;
      out_q.progress      <= {top_q, quo_q};
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

[src/bslpc_ctrl.sv]
// Controller: sequences add, evaluate, divide when needed and result load for each word.
`timescale 1ns / 1ps
`default_nettype none

module bslpc_ctrl import bslpc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire logic out_ready_i,
  output logic      out_valid_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  localparam int CntW = $clog2(Q_FRAC);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_EVAL,
    ST_DIV,
    ST_LOAD
  } state_e;

  state_e          state_q;
  logic [CntW-1:0] cnt_q;
  logic            out_valid_q;

  // Commands decoded from state
  always_comb begin
    cmd_o.in_load  = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.add      = state_q == ST_ADD;
    cmd_o.eval     = state_q == ST_EVAL;
    cmd_o.div_step = state_q == ST_DIV;
    cmd_o.out_load = (state_q == ST_LOAD) && (!out_valid_q || out_ready_i);
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;

  // State, step count and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_ADD;
        end
        ST_ADD: begin
          state_q <= ST_EVAL;
        end
        ST_EVAL: begin
          cnt_q   <= '0;
          state_q <= sts_i.need_div ? ST_DIV : ST_LOAD;
        end
        ST_DIV: begin
          if (cnt_q == CntW'(Q_FRAC - 1)) begin
            state_q <= ST_LOAD;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_LOAD: begin
          if (cmd_o.out_load) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[src/bslpc_checker.sv]
// Port-level checks for the press classifier, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bslpc_checker import bslpc_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      out_valid_i,
  input wire logic      out_ready_i,
  input wire out_word_t out_data_i
);

  // Held result stays put until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result word changed or dropped while stalled");

  // Only defined event codes
  a_event_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_data_i.press_event == EV_NONE ||
                     out_data_i.press_event == EV_SHORT ||
                     out_data_i.press_event == EV_LONG))
    else $error("undefined press event code");

  // Long press carries full progress and clears the long-press flag
  a_long_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.press_event == EV_LONG |->
      out_data_i.progress == PROG_W'(1 << Q_FRAC) && !out_data_i.in_long_press)
    else $error("long press without complete progress");

  // Short press comes with no progress and no long-press flag
  a_short_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.press_event == EV_SHORT |->
      out_data_i.progress == '0 && !out_data_i.in_long_press)
    else $error("short press with progress or long-press flag");

  // Progress never beyond one
  a_prog_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.progress <= PROG_W'(1 << Q_FRAC))
    else $error("progress above full scale");

endmodule

bind button_short_long_press_classifier bslpc_checker u_bslpc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);

`default_nettype wire

[sim/button_short_long_press_classifier_tb.sv]
// Self-checking testbench for the button short / long press classifier.
`timescale 1ns / 1ps

module button_short_long_press_classifier_tb;
  import bslpc_pkg::*;

  localparam longint unsigned TIME_MAX   = (64'd1 << DEF_TIME_BITS) - 64'd1;
  localparam longint unsigned FULL_SCALE = 64'd1 << Q_FRAC;
  localparam int unsigned     WORDS_PER_PHASE = 50;
  localparam int unsigned     RAND_PHASES     = 7;

  // Clock, reset and block ports
  logic       clk_i     = 1'b0;
  logic       rst_n     = 1'b0;
  logic       cfg_we    = 1'b0;
  cfg_idx_e   cfg_idx   = CFG_TARGET;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic       in_valid  = 1'b0;
  in_word_t   in_data   = '0;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  out_word_t  out_data;

  // Predictor copy of registers and state
  logic [CODE_W-1:0] cf_target = RST_TARGET;
  longint unsigned   cf_hold   = RST_HOLD;
  longint unsigned   cf_window = RST_WINDOW;
  logic [CODE_W-1:0] pr_code    = '0;
  longint unsigned   pr_time    = 0;
  logic              pr_fired   = 1'b0;
  logic              pr_pending = 1'b0;

  // Words waiting to be sent, results waiting to be seen
  in_word_t  word_q[$];
  out_word_t expected_press_q[$];

  // Handshake bookkeeping
  logic in_taken   = 1'b0;
  int   idle_left  = 0;
  int   stall_left = 0;
  bit   send_calm  = 1'b0;
  bit   recv_calm  = 1'b0;
  bit   soak_mode  = 1'b0;

  // Run statistics
  int n_words   = 0;
  int n_results = 0;
  int n_short   = 0;
  int n_long    = 0;
  int n_phases  = 0;
  int n_err     = 0;

  button_short_long_press_classifier i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Q12 fraction of the way from the short window to the hold time
  function automatic logic [PROG_W-1:0] q12_progress(longint unsigned t);
    if (cf_hold <= cf_window || t < cf_window) return '0;
    return PROG_W'(((t - cf_window) * FULL_SCALE) / (cf_hold - cf_window));
  endfunction

  // Classify one accepted word and advance the predicted state
  function automatic out_word_t classify_word(in_word_t w);
    out_word_t       r;
    longint unsigned t;
    r = '0;
    r.press_event = EV_NONE;
    if (pr_code != w.next_code) begin
      if (pr_code == cf_target && !pr_fired) begin
        // no short press once held beyond a non-zero window
        if (cf_window != 0 && pr_time > cf_window) r.press_event = EV_NONE;
        else r.press_event = EV_SHORT;
      end
      pr_code    = w.next_code;
      pr_time    = 0;
      pr_fired   = 1'b0;
      pr_pending = 1'b0;
    end else if (w.next_code == cf_target && !pr_fired) begin
      t = pr_time + longint'(w.delta_ticks);
      if (t > TIME_MAX) t = TIME_MAX;
      if (t > cf_window) pr_pending = 1'b1;
      if (t > cf_hold) begin
        pr_time       = 0;
        pr_fired      = 1'b1;
        pr_pending    = 1'b0;
        r.press_event = EV_LONG;
        r.progress    = PROG_W'(FULL_SCALE);
      end else begin
        pr_time    = t;
        r.progress = q12_progress(t);
      end
      r.in_long_press = pr_pending;
    end else begin
      r.in_long_press = pr_pending;
    end
    return r;
  endfunction

  // Gap length: mostly none or short, now and then long
  function automatic int idle_length(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 48);
  endfunction

  // Tick count scaled to the hold time, with full-range values mixed in
  function automatic logic [DELTA_W-1:0] pick_delta();
    int              r;
    longint unsigned span;
    r    = $urandom_range(0, 9);
    span = cf_hold / 4 + 1;
    if (span > 65535) span = 65535;
    if (r < 2) return DELTA_W'($urandom());
    if (r == 2) return ($urandom_range(0, 1) != 0) ? '1 : '0;
    return DELTA_W'($urandom_range(0, int'(span)));
  endfunction

  task automatic push_word(logic [CODE_W-1:0] code, logic [DELTA_W-1:0] delta);
    in_word_t w;
    w.next_code   = code;
    w.delta_ticks = delta;
    word_q.push_back(w);
    n_words++;
  endtask

  // Single register write; the block is idle whenever this is called
  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_TARGET: cf_target = data[CODE_W-1:0];
      CFG_HOLD:   cf_hold   = data;
      CFG_WINDOW: cf_window = data;
      default: ;
    endcase
  endtask

  task automatic write_all(logic [CODE_W-1:0] tgt, logic [CFG_W-1:0] hold,
                           logic [CFG_W-1:0] win);
    // junk above the code width must be dropped by the block
    write_reg(CFG_TARGET, ($urandom() & ~CFG_W'(4'hF)) | CFG_W'(tgt));
    write_reg(CFG_HOLD, hold);
    write_reg(CFG_WINDOW, win);
    n_phases++;
  endtask

  // Wait until every word is sent and every result has come back
  task automatic drain_block();
    while (word_q.size() != 0 || in_valid || expected_press_q.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // One random press sequence, mostly well formed
  task automatic gen_press_run();
    int                kind;
    logic [CODE_W-1:0] other;
    logic [CODE_W-1:0] rel;
    kind  = $urandom_range(0, 99);
    other = cf_target + CODE_W'($urandom_range(1, 15));
    rel   = (cf_target != 0 && $urandom_range(0, 2) != 0) ? '0 : other;
    if (kind < 70) begin
      if ($urandom_range(0, 1) != 0) push_word(other, pick_delta());
      push_word(cf_target, pick_delta());
      repeat ($urandom_range(1, 8)) push_word(cf_target, pick_delta());
      push_word(rel, pick_delta());
    end else if (kind < 85) begin
      repeat ($urandom_range(2, 4)) push_word(other, pick_delta());
    end else begin
      repeat ($urandom_range(1, 3))
        push_word(CODE_W'($urandom()), DELTA_W'($urandom()));
    end
  endtask

  // Sender: present the next word at the falling edge, hold it until taken
  always @(negedge clk_i) begin
    if (in_valid && !in_taken) begin
      // word still waiting for the block
    end else if (idle_left > 0 || word_q.size() == 0) begin
      in_valid <= 1'b0;
      if (idle_left > 0) idle_left--;
    end else begin
      in_data   <= word_q.pop_front();
      in_valid  <= 1'b1;
      idle_left = idle_length(send_calm || soak_mode);
      if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
    end
  end

  // Receiver: random back-pressure
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 5) == 0) stall_left = idle_length(recv_calm || soak_mode);
      if ($urandom_range(0, 47) == 0) recv_calm = !recv_calm;
    end
  end

  // Monitor: predict on each accepted word, check each accepted result
  always @(posedge clk_i) begin
    out_word_t want;
    in_taken <= in_valid && in_ready;
    if (rst_n && in_valid && in_ready) expected_press_q.push_back(classify_word(in_data));
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (out_data.press_event == EV_SHORT) n_short++;
      if (out_data.press_event == EV_LONG) n_long++;
      if (expected_press_q.size() == 0) begin
        $error("result word with nothing expected: event %0d",
               out_data.press_event);
        n_err++;
      end else begin
        want = expected_press_q.pop_front();
        if (out_data.press_event !== want.press_event) begin
          $error("press_event: expected %0d, actual %0d",
                 want.press_event, out_data.press_event);
          n_err++;
        end
        if (out_data.in_long_press !== want.in_long_press) begin
          $error("in_long_press: expected %0d, actual %0d",
                 want.in_long_press, out_data.in_long_press);
          n_err++;
        end
        if (out_data.progress !== want.progress) begin
          $error("progress: expected %0d, actual %0d",
                 want.progress, out_data.progress);
          n_err++;
        end
      end
    end
  end

  // Stimulus sequence
  initial begin
    logic [CFG_W-1:0] hold;
    logic [CFG_W-1:0] win;
    logic [CODE_W-1:0] tgt;
    int phase_start;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;

    // Reset settings: short press inside the window
    push_word(4'd1, 16'd0);
    push_word(4'd1, 16'd100);
    push_word(4'd0, 16'd0);
    // long press fires once, its release reports nothing
    push_word(4'd1, 16'hFFFF);
    push_word(4'd1, 16'hFFFF);
    push_word(4'd1, 16'hFFFF);
    push_word(4'd0, 16'd5);
    // walk through the window up to full scale, then fire
    push_word(4'd1, 16'd0);
    push_word(4'd1, 16'd200);
    push_word(4'd1, 16'd200);
    push_word(4'd1, 16'd600);
    push_word(4'd1, 16'd1);
    // another code held
    push_word(4'd2, 16'd0);
    push_word(4'd2, 16'd500);
    // held past the window and released: no short press
    push_word(4'd1, 16'd0);
    push_word(4'd1, 16'd400);
    push_word(4'd15, 16'd0);
    push_word(4'd15, 16'hFFFF);
    push_word(4'd0, 16'hFFFF);
    // in-long-press raised, then target moved away mid-hold
    push_word(4'd1, 16'd0);
    push_word(4'd1, 16'd400);
    drain_block();
    write_reg(CFG_TARGET, 32'd5);
    push_word(4'd1, 16'd10);
    push_word(4'd0, 16'd0);
    push_word(4'd5, 16'd0);
    push_word(4'd5, 16'd10);
    push_word(4'd0, 16'd0);
    drain_block();

    // Hold equal to window
    write_all(4'd5, 32'd500, 32'd500);
    push_word(4'd5, 16'd0);
    push_word(4'd5, 16'd500);
    push_word(4'd5, 16'd1);
    push_word(4'd0, 16'd0);
    drain_block();
    // Hold shorter than window
    write_all(4'd5, 32'd100, 32'd800);
    push_word(4'd5, 16'd0);
    push_word(4'd5, 16'd50);
    push_word(4'd5, 16'd51);
    push_word(4'd0, 16'd0);
    drain_block();
    // Window zero: any release before firing is a short press
    write_all(4'd3, '1, '0);
    push_word(4'd3, 16'd0);
    repeat (3) push_word(4'd3, 16'hFFFF);
    push_word(4'd0, 16'd0);
    drain_block();

    // Long hold over a wide span, full-range ticks until it fires
    soak_mode = 1'b1;
    write_all(4'd3, 32'h0018_0000, 32'h0008_0000);
    push_word(4'd3, 16'd0);
    repeat (30) push_word(4'd3, 16'hFFFF);
    push_word(4'd0, 16'd0);
    drain_block();
    soak_mode = 1'b0;

    // Random phases over a spread of settings
    for (int p = 0; p < RAND_PHASES; p++) begin
      tgt  = CODE_W'($urandom_range(0, 15));
      hold = $urandom_range(20, 3000);
      win  = $urandom_range(0, hold);
      case (p)
        0: begin tgt = 4'd1; hold = RST_HOLD; win = RST_WINDOW; end
        2: win = '0;
        3: win = hold + $urandom_range(1, 2000);
        4: win = hold;
        5: begin hold = $urandom(); win = $urandom(); end
        6: begin tgt = 4'd0; hold = '0; win = $urandom_range(0, 100); end
        default: ;
      endcase
      if (p == 1) tgt = 4'd15;
      write_all(tgt, hold, win);
      phase_start = n_words;
      while (n_words - phase_start < int'(WORDS_PER_PHASE)) begin
        gen_press_run();
        // pause mid-phase until the block has caught up
        if (word_q.size() > WORDS_PER_PHASE / 2 && $urandom_range(0, 3) == 0)
          drain_block();
      end
      drain_block();
    end

    drain_block();
    $display("Run covered %0d words across %0d register settings.", n_words, n_phases);
    $display("Checked %0d results: %0d short and %0d long presses, %0d mismatches.",
             n_results, n_short, n_long, n_err);
    if (n_err == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #30_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[filelist.f]
src/bslpc_pkg.sv
src/bslpc_datapath.sv
src/bslpc_ctrl.sv
src/button_short_long_press_classifier.sv
src/bslpc_checker.sv
sim/button_short_long_press_classifier_tb.sv
